// ===== hdl/pba_pkg.sv =====
// Shared definitions for the page bitmap allocator: command codes, word geometry
// and the lowest-free-bit search used by the allocation step.
// Depends on nothing; used by the top level, its port checker and the testbench.
package pba_pkg;

    // Bits per bitmap word; the page number splits into word index and bit index.
    localparam int WORD_BITS = 32;
    localparam int BIT_W = $clog2(WORD_BITS);

    // Width of the page number fields on the ports.
    localparam int PAGE_NUM_W = 12;

    // Default number of page frames that the bitmap covers.
    localparam int PAGE_COUNT_DEF = 4096;

    typedef enum logic [1:0] {
        CMD_MARK_USED = 2'd0,
        CMD_MARK_FREE = 2'd1,
        CMD_QUERY     = 2'd2,
        CMD_ALLOC     = 2'd3
    } cmd_t;

    typedef logic [WORD_BITS-1:0] word_t;

    // Returns {found, index} of the lowest clear bit of a bitmap word.
    function automatic logic [BIT_W:0] lowest_zero(input word_t w);
        logic [BIT_W:0] res;
        res = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                res = {1'b1, BIT_W'(i)};
            end
        end
        return res;
    endfunction

endpackage

// ===== hdl/page_bitmap_allocator_top.sv =====
// Page bitmap allocator top level: bitmap memory, command sequencer and
// first-fit word scan. Depends on pba_pkg for command codes and word geometry.
//
// Usage: a command transaction is accepted at a rising edge with start high and
// busy low; command selects mark used, mark free, query or allocate, and
// page_number names the page for the first three. Every command gives exactly
// one result transaction, shown for one cycle with done high on page_used,
// granted and granted_page. The receiver cannot hold results off.
// Sequence: a mark or query takes one memory read, then one write or compare,
// and done is registered from that write or compare. An allocation reads one
// bitmap word per cycle, starting at the lowest word that may still hold a free
// page (a low-water pointer kept in a register), and stops at the first word
// with a free page or after the last word. A mark or query on a page at or
// beyond PAGE_COUNT, and an allocate when the pointer says every word is full,
// answer in the cycle after acceptance without becoming busy.
// Reset: the bitmap is cleared by a pass that writes one word per cycle, so
// busy stays high after reset until the pass has written the last word.
module page_bitmap_allocator_top #(
    parameter int PAGE_COUNT = pba_pkg::PAGE_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      command,
    input  logic [pba_pkg::PAGE_NUM_W-1:0]  page_number,
    output logic                            done,
    output logic                            page_used,
    output logic                            granted,
    output logic [pba_pkg::PAGE_NUM_W-1:0]  granted_page
);

    localparam int WB = pba_pkg::WORD_BITS;
    localparam int BW = pba_pkg::BIT_W;
    localparam int PNW = pba_pkg::PAGE_NUM_W;
    localparam int WORD_COUNT = (PAGE_COUNT + WB - 1) / WB;
    localparam int WIDX = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int PTRW = $clog2(WORD_COUNT + 1);
    localparam int PW = $clog2(PAGE_COUNT);
    // Compare width: wide enough for both the port field and PAGE_COUNT.
    localparam int CMPW = ((PW > PNW) ? PW : PNW) + 1;
    localparam logic [WIDX-1:0] LAST_WORD = WIDX'(WORD_COUNT - 1);
    localparam logic [PTRW-1:0] PTR_FULL = PTRW'(WORD_COUNT);
    localparam logic [CMPW-1:0] PAGE_LIMIT = CMPW'(PAGE_COUNT);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    pba_pkg::cmd_t          cmd_reg, cmd_next;
    logic [WIDX-1:0]        word_reg, word_next;
    logic [BW-1:0]          bit_reg, bit_next;
    logic [PTRW-1:0]        free_ptr_reg, free_ptr_next;
    logic [WIDX-1:0]        clr_reg, clr_next;
    logic                   done_reg, done_next;
    logic                   used_reg, used_next;
    logic                   granted_reg, granted_next;
    logic [PNW-1:0]         gpage_reg, gpage_next;

    // Bitmap storage: one word per entry, registered read data.
    pba_pkg::word_t         bitmap_mem [WORD_COUNT];
    pba_pkg::word_t         rdata_reg;
    logic                   rd_en;
    logic [WIDX-1:0]        rd_addr;
    logic                   wr_en;
    logic [WIDX-1:0]        wr_addr;
    pba_pkg::word_t         wr_data;

    // Input decode.
    logic [CMPW-1:0]        page_ext;
    logic                   in_range;
    logic [WIDX-1:0]        in_word;
    logic [BW-1:0]          in_bit;
    logic [WIDX-1:0]        ptr_word;

    // Allocation search on the word just read.
    logic [BW:0]            lz;
    logic [BW-1:0]          zbit;
    logic [CMPW-1:0]        cand_page;
    logic                   cand_ok;
    pba_pkg::word_t         bit_mask;
    pba_pkg::word_t         grant_mask;
    pba_pkg::word_t         grant_word;

    assign page_ext = CMPW'(page_number);
    assign in_range = (page_ext < PAGE_LIMIT);
    assign in_word  = WIDX'(page_ext >> BW);
    assign in_bit   = page_number[BW-1:0];
    assign ptr_word = WIDX'(free_ptr_reg);

    assign lz         = pba_pkg::lowest_zero(rdata_reg);
    assign zbit       = lz[BW-1:0];
    assign cand_page  = CMPW'({word_reg, zbit});
    // Bits past PAGE_COUNT in a partial last word never count as free.
    assign cand_ok    = lz[BW] && (cand_page < PAGE_LIMIT);
    assign bit_mask   = WB'(1) << bit_reg;
    assign grant_mask = WB'(1) << zbit;
    assign grant_word = rdata_reg | grant_mask;

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        word_next     = word_reg;
        bit_next      = bit_reg;
        free_ptr_next = free_ptr_reg;
        clr_next      = clr_reg;
        done_next     = 1'b0;
        used_next     = 1'b0;
        granted_next  = 1'b0;
        gpage_next    = '0;
        rd_en         = 1'b0;
        rd_addr       = in_word;
        wr_en         = 1'b0;
        wr_addr       = word_reg;
        wr_data       = rdata_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
                if (clr_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + WIDX'(1);
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = pba_pkg::cmd_t'(command);
                    bit_next = in_bit;
                    if (pba_pkg::cmd_t'(command) == pba_pkg::CMD_ALLOC)
                    begin
                        if (free_ptr_reg == PTR_FULL)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = ptr_word;
                            word_next  = ptr_word;
                            state_next = ST_EXEC;
                        end
                    end
                    else if (in_range)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = in_word;
                        word_next  = in_word;
                        state_next = ST_EXEC;
                    end
                    else
                    begin
                        // Page beyond the bitmap: nothing changes, all-zero result.
                        done_next = 1'b1;
                    end
                end
            end

            ST_EXEC:
            begin
                case (cmd_reg)
                    pba_pkg::CMD_MARK_USED:
                    begin
                        wr_en      = 1'b1;
                        wr_data    = rdata_reg | bit_mask;
                        done_next  = 1'b1;
                        used_next  = 1'b1;
                        state_next = ST_IDLE;
                    end

                    pba_pkg::CMD_MARK_FREE:
                    begin
                        wr_en      = 1'b1;
                        wr_data    = rdata_reg & ~bit_mask;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                        if (PTRW'(word_reg) < free_ptr_reg)
                        begin
                            free_ptr_next = PTRW'(word_reg);
                        end
                    end

                    pba_pkg::CMD_QUERY:
                    begin
                        done_next  = 1'b1;
                        used_next  = rdata_reg[bit_reg];
                        state_next = ST_IDLE;
                    end

                    pba_pkg::CMD_ALLOC:
                    begin
                        if (cand_ok)
                        begin
                            wr_en        = 1'b1;
                            wr_data      = grant_word;
                            done_next    = 1'b1;
                            used_next    = 1'b1;
                            granted_next = 1'b1;
                            gpage_next   = PNW'({word_reg, zbit});
                            state_next   = ST_IDLE;
                            // Every word below the pointer is known to be full.
                            if (&grant_word)
                            begin
                                free_ptr_next = PTRW'(word_reg) + PTRW'(1);
                            end
                            else
                            begin
                                free_ptr_next = PTRW'(word_reg);
                            end
                        end
                        else if (word_reg == LAST_WORD)
                        begin
                            done_next     = 1'b1;
                            free_ptr_next = PTR_FULL;
                            state_next    = ST_IDLE;
                        end
                        else
                        begin
                            rd_en     = 1'b1;
                            rd_addr   = word_reg + WIDX'(1);
                            word_next = word_reg + WIDX'(1);
                        end
                    end

                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            free_ptr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            free_ptr_reg <= free_ptr_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        word_reg <= word_next;
        bit_reg  <= bit_next;
        if (done_next)
        begin
            used_reg    <= used_next;
            granted_reg <= granted_next;
            gpage_reg   <= gpage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bitmap_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= bitmap_mem[rd_addr];
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign page_used    = used_reg;
    assign granted      = granted_reg;
    assign granted_page = gpage_reg;

endmodule

// ===== hdl/pba_checker.sv =====
// Port-level checker for the page bitmap allocator and its bind to the top level.
// Depends on pba_pkg for command codes.
module pba_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic [1:0]                      command,
    input logic                            done,
    input logic                            page_used,
    input logic                            granted,
    input logic [pba_pkg::PAGE_NUM_W-1:0]  granted_page
);

    // A result transaction is never shown while a command is still in progress.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // A granted page is always reported as used.
    a_grant_used: assert property (@(posedge clk) disable iff (!rst_n)
        done && granted |-> page_used)
        else $error("granted page not reported as used");

    // Without a grant, the page number field is zero.
    a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !granted |-> granted_page == '0)
        else $error("page number given without a grant");

    // A mark-free or query command either starts work or answers at once without a grant.
    a_mark_free: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && command == pba_pkg::CMD_MARK_FREE
        |=> busy || (done && !page_used && !granted))
        else $error("mark free gave a wrong or missing result");

    a_query_follow: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && command == pba_pkg::CMD_QUERY
        |=> busy || (done && !granted))
        else $error("query gave a wrong or missing result");

endmodule

bind page_bitmap_allocator_top pba_checker u_pba_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .done         (done),
    .page_used    (page_used),
    .granted      (granted),
    .granted_page (granted_page)
);

// ===== tb/page_bitmap_checker.sv =====
`timescale 1ns / 100ps
// Checker for the page bitmap allocator: watches the command and result ports,
// keeps its own copy of the page bitmap and compares every result in order.
// Depends on pba_pkg for command codes, word geometry and port widths.
module page_bitmap_checker #(
    parameter int PAGE_COUNT = pba_pkg::PAGE_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [1:0]                      command,
    input  logic [pba_pkg::PAGE_NUM_W-1:0]  page_number,
    input  logic                            done,
    input  logic                            page_used,
    input  logic                            granted,
    input  logic [pba_pkg::PAGE_NUM_W-1:0]  granted_page,
    output int                              error_count,
    output int                              pending_count
);

    localparam int WB = pba_pkg::WORD_BITS;
    localparam int PNW = pba_pkg::PAGE_NUM_W;
    localparam int WORD_COUNT = (PAGE_COUNT + WB - 1) / WB;

    typedef struct packed {
        logic            page_used;
        logic            granted;
        logic [PNW-1:0]  granted_page;
    } page_result_t;

    pba_pkg::word_t page_map [WORD_COUNT];
    page_result_t   expected_results [$];

    initial
    begin
        error_count   = 0;
        pending_count = 0;
        for (int w = 0; w < WORD_COUNT; w++)
        begin
            page_map[w] = '0;
        end
    end

    // Applies one command to the local bitmap and returns the result it gives.
    function automatic page_result_t apply_page_command(input pba_pkg::cmd_t cmd,
                                                        input logic [PNW-1:0] page);
        page_result_t res;
        bit           found;
        int           p;
        res   = '0;
        found = 1'b0;
        if (cmd == pba_pkg::CMD_ALLOC)
        begin
            for (int w = 0; w < WORD_COUNT && !found; w++)
            begin
                if (page_map[w] != '1)
                begin
                    for (int b = 0; b < WB && !found; b++)
                    begin
                        p = w * WB + b;
                        if (p < PAGE_COUNT && !page_map[w][b])
                        begin
                            page_map[w][b]   = 1'b1;
                            found            = 1'b1;
                            res.page_used    = 1'b1;
                            res.granted      = 1'b1;
                            res.granted_page = PNW'(p);
                        end
                    end
                end
            end
        end
        else if (int'(page) < PAGE_COUNT)
        begin
            case (cmd)
                pba_pkg::CMD_MARK_USED:
                begin
                    page_map[page / WB][page % WB] = 1'b1;
                    res.page_used = 1'b1;
                end
                pba_pkg::CMD_MARK_FREE:
                begin
                    page_map[page / WB][page % WB] = 1'b0;
                end
                default:
                begin
                    res.page_used = page_map[page / WB][page % WB];
                end
            endcase
        end
        return res;
    endfunction

    always @(posedge clk)
    begin
        page_result_t exp_res;
        if (rst_n)
        begin
            // A result always belongs to a command accepted at an earlier edge.
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with no command pending");
                    error_count++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (page_used !== exp_res.page_used)
                    begin
                        $error("page_used: expected %0d, actual %0d",
                               exp_res.page_used, page_used);
                        error_count++;
                    end
                    if (granted !== exp_res.granted)
                    begin
                        $error("granted: expected %0d, actual %0d",
                               exp_res.granted, granted);
                        error_count++;
                    end
                    if (granted_page !== exp_res.granted_page)
                    begin
                        $error("granted_page: expected %0d, actual %0d",
                               exp_res.granted_page, granted_page);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                expected_results.push_back(
                    apply_page_command(pba_pkg::cmd_t'(command), page_number));
            end
            pending_count = expected_results.size();
        end
    end

endmodule

// ===== tb/tb_page_bitmap_allocator_top.sv =====
`timescale 1ns / 100ps
// Top of the page bitmap allocator testbench: clock, reset, command stimulus and verdict.
// Depends on pba_pkg, page_bitmap_allocator_top and page_bitmap_checker.
module tb_page_bitmap_allocator_top;

    localparam int PAGE_COUNT = pba_pkg::PAGE_COUNT_DEF;
    localparam int WORD_COUNT = PAGE_COUNT / pba_pkg::WORD_BITS;
    localparam int PNW = pba_pkg::PAGE_NUM_W;

    // The slowest allocation scans every word; the drain at the end waits a
    // little longer than that after the last result has come back.
    localparam int DRAIN_CYCLES = 2 * WORD_COUNT + 16;

    // Generous bound on the whole run: even if every allocation scanned the
    // whole bitmap and the sender stalled at length, this would not be reached.
    localparam int CYCLE_LIMIT = 5_000_000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [1:0]             command = pba_pkg::CMD_QUERY;
    logic [PNW-1:0]         page_number = '0;
    logic                   done;
    logic                   page_used;
    logic                   granted;
    logic [PNW-1:0]         granted_page;

    int error_count;
    int pending_count;
    int cycle_count = 0;

    // Percentage of cycles in which the sender holds start low between commands.
    int idle_pct = 0;

    always #5 clk = ~clk;

    page_bitmap_allocator_top #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .page_number  (page_number),
        .done         (done),
        .page_used    (page_used),
        .granted      (granted),
        .granted_page (granted_page)
    );

    page_bitmap_checker #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .page_number   (page_number),
        .done          (done),
        .page_used     (page_used),
        .granted       (granted),
        .granted_page  (granted_page),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Issues one command transaction. The task is entered just after a rising
    // edge and returns just after the edge that accepted the command, so that
    // back-to-back commands keep start high without lowering it in between.
    // Busy is read right after the edge, which still shows its value from
    // before the edge, the same value that the block itself saw.
    task automatic send_command(input pba_pkg::cmd_t cmd, input logic [PNW-1:0] page);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            command <= pba_pkg::cmd_t'($urandom_range(3));
            page_number <= PNW'($urandom);
            @(posedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        page_number <= page;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    // Random mix of all four commands. Half of the page numbers fall in the
    // low window where first-fit allocation places pages, so that queries and
    // frees hit used pages often; the other half span the whole field.
    task automatic run_mixed_commands(input int count);
        int            pick;
        pba_pkg::cmd_t cmd;
        logic [PNW-1:0] page;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                cmd = pba_pkg::CMD_ALLOC;
            end
            else if (pick < 55)
            begin
                cmd = pba_pkg::CMD_MARK_FREE;
            end
            else if (pick < 75)
            begin
                cmd = pba_pkg::CMD_QUERY;
            end
            else
            begin
                cmd = pba_pkg::CMD_MARK_USED;
            end
            if ($urandom_range(1))
            begin
                page = PNW'($urandom_range(255));
            end
            else
            begin
                page = PNW'($urandom);
            end
            send_command(cmd, page);
        end
    endtask

    initial
    begin
        // Reset is held low at the start and released once; the block then
        // clears its bitmap while busy is high, which the handshake absorbs.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed commands: the empty bitmap, both ends of the page range,
        // every command, alternating bit patterns in the page number, marks
        // that do not change the page, and allocation after pages around the
        // low end have been taken and given back.
        idle_pct = 0;
        send_command(pba_pkg::CMD_QUERY, 12'd0);
        send_command(pba_pkg::CMD_QUERY, 12'hFFF);
        send_command(pba_pkg::CMD_ALLOC, 12'hFFF);
        send_command(pba_pkg::CMD_ALLOC, 12'h000);
        send_command(pba_pkg::CMD_MARK_USED, 12'hFFF);
        send_command(pba_pkg::CMD_QUERY, 12'hFFF);
        send_command(pba_pkg::CMD_MARK_USED, 12'hFFF);
        send_command(pba_pkg::CMD_MARK_FREE, 12'hFFF);
        send_command(pba_pkg::CMD_QUERY, 12'hFFF);
        send_command(pba_pkg::CMD_MARK_FREE, 12'hFFF);
        send_command(pba_pkg::CMD_MARK_USED, 12'hAAA);
        send_command(pba_pkg::CMD_MARK_USED, 12'h555);
        send_command(pba_pkg::CMD_QUERY, 12'hAAA);
        send_command(pba_pkg::CMD_QUERY, 12'h555);
        send_command(pba_pkg::CMD_MARK_USED, 12'd2);
        send_command(pba_pkg::CMD_ALLOC, 12'h555);
        send_command(pba_pkg::CMD_MARK_FREE, 12'd0);
        send_command(pba_pkg::CMD_ALLOC, 12'hAAA);
        send_command(pba_pkg::CMD_MARK_USED, 12'd31);
        send_command(pba_pkg::CMD_MARK_USED, 12'd32);
        send_command(pba_pkg::CMD_ALLOC, 12'd0);
        send_command(pba_pkg::CMD_QUERY, 12'd4);
        send_command(pba_pkg::CMD_MARK_FREE, 12'hAAA);
        send_command(pba_pkg::CMD_QUERY, 12'hAAA);

        // First random phase: the sender idles now and then.
        idle_pct = 16;
        run_mixed_commands(600);

        // Second random phase: the sender idles most of the time, so gaps
        // land on every cycle of the mark, query and scan sequences.
        idle_pct = 66;
        run_mixed_commands(600);

        // Third phase, with no idling. A run of allocations fills several
        // words in a row and moves the low-water pointer up; then frees in
        // the filled region are followed by allocations, which must hand the
        // freed pages out again lowest first.
        idle_pct = 0;
        for (int i = 0; i < 200; i++)
        begin
            send_command(pba_pkg::CMD_ALLOC, PNW'($urandom));
        end
        for (int i = 0; i < 60; i++)
        begin
            send_command(pba_pkg::CMD_MARK_FREE, PNW'($urandom_range(511)));
            send_command(pba_pkg::CMD_QUERY, PNW'($urandom_range(511)));
            send_command(pba_pkg::CMD_ALLOC, PNW'($urandom));
            send_command(pba_pkg::CMD_ALLOC, PNW'($urandom));
        end
        run_mixed_commands(150);

        // Stop issuing commands, wait for every pending result, then let the
        // block run for longer than its slowest scan before the verdict.
        start <= 1'b0;
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
